FILE: src/sgct_pkg.sv
// Shared constants, codes and helpers for the segment gate crossing test.
package sgct_pkg;

  localparam int CW    = 21;  // coordinate width, cm
  localparam int AXW   = 16;  // axis component width, Q1.14
  localparam int DSTW  = 28;  // reported distance/offset width
  localparam int ALW   = 17;  // alpha width, Q1.16
  localparam int NDIV  = 17;  // quotient bits, one per divider stage
  localparam int HSW   = 20;  // half size width
  localparam int CFGW  = 63;  // widest register
  localparam int CIDXW = 3;

  typedef enum logic [CIDXW-1:0] {
    REG_ORIGIN = 3'd0,
    REG_NORMAL = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_UP     = 3'd3,
    REG_HALF_W = 3'd4,
    REG_HALF_H = 3'd5,
    REG_LEGAL  = 3'd6,
    REG_SPARE  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_FWD     = 2'd1,
    KIND_REV     = 2'd2,
    KIND_OUTSIDE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_REV  = 2'd1,
    DIR_BOTH = 2'd2,
    DIR_NONE = 2'd3
  } dir_t;

  function automatic logic signed [DSTW-1:0] sat28(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd134217727;
    lo = -48'sd134217728;
    if (v > hi) sat28 = hi[DSTW-1:0];
    else if (v < lo) sat28 = lo[DSTW-1:0];
    else sat28 = v[DSTW-1:0];
  endfunction

endpackage

FILE: src/segment_gate_crossing_test.sv
// Pipelined test of one motion segment against one configured gate rectangle.

// Takes one segment request per clock while in_stall is low and returns one result per
// request in order. The pipeline has three stages for the plane distances, a
// 17-stage restoring divider that makes one alpha bit per stage, and six stages
// for the crossing point, offsets, extent test and output register.
// The whole pipeline holds while a finished result is stalled at the output; bubbles
// still advance otherwise. Gate registers are read live by the stages that use them,
// so write them only while the pipeline is empty.
module segment_gate_crossing_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [20:0]            in_from_x,
  input  logic signed [20:0]            in_from_y,
  input  logic signed [20:0]            in_from_z,
  input  logic signed [20:0]            in_to_x,
  input  logic signed [20:0]            in_to_y,
  input  logic signed [20:0]            in_to_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_crossing_kind,
  output logic                          out_direction_ok,
  output logic [16:0]                   out_alpha,
  output logic signed [27:0]            out_dist_start,
  output logic signed [27:0]            out_dist_end,
  output logic signed [27:0]            out_lateral_offset,
  output logic signed [27:0]            out_vertical_offset,
  output logic signed [20:0]            out_hit_x,
  output logic signed [20:0]            out_hit_y,
  output logic signed [20:0]            out_hit_z,
  input  logic                          cfg_we,
  input  logic [sgct_pkg::CIDXW-1:0]    cfg_index,
  input  logic [sgct_pkg::CFGW-1:0]     cfg_wdata
);

  localparam int ND = sgct_pkg::NDIV;

  // ---------------- configuration ----------------
  logic [62:0] origin_r;
  logic [47:0] normal_r, right_r, up_r;
  logic [19:0] hw_r, hh_r;
  logic [1:0]  legal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      normal_r <= '0;
      right_r  <= '0;
      up_r     <= '0;
      hw_r     <= 20'd1;
      hh_r     <= 20'd1;
      legal_r  <= sgct_pkg::DIR_FWD;
    end else if (cfg_we) begin
      case (sgct_pkg::cfg_reg_t'(cfg_index))
        sgct_pkg::REG_ORIGIN: origin_r <= cfg_wdata[62:0];
        sgct_pkg::REG_NORMAL: normal_r <= cfg_wdata[47:0];
        sgct_pkg::REG_RIGHT:  right_r  <= cfg_wdata[47:0];
        sgct_pkg::REG_UP:     up_r     <= cfg_wdata[47:0];
        sgct_pkg::REG_HALF_W: hw_r     <= cfg_wdata[19:0];
        sgct_pkg::REG_HALF_H: hh_r     <= cfg_wdata[19:0];
        sgct_pkg::REG_LEGAL:  legal_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic signed [20:0] org [3];
  logic signed [15:0] nrm [3];
  logic signed [15:0] rgt [3];
  logic signed [15:0] upa [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = $signed(origin_r[21*i +: 21]);
      nrm[i] = $signed(normal_r[16*i +: 16]);
      rgt[i] = $signed(right_r[16*i +: 16]);
      upa[i] = $signed(up_r[16*i +: 16]);
    end
  end

  // ---------------- flow control ----------------
  logic out_valid_r;
  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  logic signed [20:0] in_from [3];
  logic signed [20:0] in_to   [3];
  assign in_from[0] = in_from_x;
  assign in_from[1] = in_from_y;
  assign in_from[2] = in_from_z;
  assign in_to[0]   = in_to_x;
  assign in_to[1]   = in_to_y;
  assign in_to[2]   = in_to_z;

  // ---------------- S1: differences ----------------
  logic               v1_r;
  logic signed [21:0] rs1_r [3];
  logic signed [21:0] re1_r [3];
  logic signed [21:0] del1_r [3];
  logic signed [20:0] from1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rs1_r[i]   <= 22'(in_from[i]) - 22'(org[i]);
        re1_r[i]   <= 22'(in_to[i]) - 22'(org[i]);
        del1_r[i]  <= 22'(in_to[i]) - 22'(in_from[i]);
        from1_r[i] <= in_from[i];
      end
    end
  end

  // ---------------- S2: normal products ----------------
  logic               v2_r;
  logic signed [37:0] ps2_r [3];
  logic signed [37:0] pe2_r [3];
  logic signed [21:0] del2_r [3];
  logic signed [20:0] from2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ps2_r[i]   <= rs1_r[i] * nrm[i];
        pe2_r[i]   <= re1_r[i] * nrm[i];
        del2_r[i]  <= del1_r[i];
        from2_r[i] <= from1_r[i];
      end
    end
  end

  // ---------------- S3: plane distances ----------------
  logic signed [39:0] sum_s, sum_e;
  logic signed [39:0] rnd_s, rnd_e;
  assign sum_s = 40'(ps2_r[0]) + 40'(ps2_r[1]) + 40'(ps2_r[2]);
  assign sum_e = 40'(pe2_r[0]) + 40'(pe2_r[1]) + 40'(pe2_r[2]);
  assign rnd_s = (sum_s + 40'sd512) >>> 10;
  assign rnd_e = (sum_e + 40'sd512) >>> 10;

  logic               v3_r;
  logic signed [27:0] ds3_r, de3_r;
  logic signed [21:0] del3_r [3];
  logic signed [20:0] from3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds3_r <= sgct_pkg::sat28(48'(rnd_s));
      de3_r <= sgct_pkg::sat28(48'(rnd_e));
      for (int i = 0; i < 3; i++) begin
        del3_r[i]  <= del2_r[i];
        from3_r[i] <= from2_r[i];
      end
    end
  end

  // divider setup: alpha = floor((num*2^17 + den) / (2*den))
  logic        fwd3, rev3;
  logic [27:0] num3, den3;
  logic [45:0] rem_init;
  assign fwd3     = ds3_r[27] && !de3_r[27];
  assign rev3     = de3_r[27] && !ds3_r[27];
  assign num3     = fwd3 ? 28'(-ds3_r) : 28'(ds3_r);
  assign den3     = fwd3 ? 28'(de3_r - ds3_r) : 28'(ds3_r - de3_r);
  assign rem_init = {1'b0, num3, 17'd0} + 46'(den3);

  // ---------------- divider stages ----------------
  logic               dv_r   [ND];
  logic [45:0]        drem_r [ND];
  logic [28:0]        ddiv_r [ND];
  logic [16:0]        dq_r   [ND];
  logic               dfwd_r [ND];
  logic               drev_r [ND];
  logic signed [27:0] dds_r  [ND];
  logic signed [27:0] dde_r  [ND];
  logic signed [21:0] ddel_r [ND][3];
  logic signed [20:0] dfrom_r[ND][3];

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic               pv;
    logic [45:0]        prem;
    logic [28:0]        pdiv;
    logic [16:0]        pq;
    logic               pfwd, prev;
    logic signed [27:0] pds, pde;
    logic signed [21:0] pdel [3];
    logic signed [20:0] pfrom [3];
    logic [45:0]        shd;
    logic               ge;

    if (k == 0) begin : g_first
      always_comb begin
        pv   = v3_r;
        prem = rem_init;
        pdiv = {1'b0, den3} << 1;
        pq   = '0;
        pfwd = fwd3;
        prev = rev3;
        pds  = ds3_r;
        pde  = de3_r;
        for (int i = 0; i < 3; i++) begin
          pdel[i]  = del3_r[i];
          pfrom[i] = from3_r[i];
        end
      end
    end else begin : g_next
      always_comb begin
        pv   = dv_r[k-1];
        prem = drem_r[k-1];
        pdiv = ddiv_r[k-1];
        pq   = dq_r[k-1];
        pfwd = dfwd_r[k-1];
        prev = drev_r[k-1];
        pds  = dds_r[k-1];
        pde  = dde_r[k-1];
        for (int i = 0; i < 3; i++) begin
          pdel[i]  = ddel_r[k-1][i];
          pfrom[i] = dfrom_r[k-1][i];
        end
      end
    end

    assign shd = 46'(pdiv) << (ND - 1 - k);
    assign ge  = prem >= shd;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k] <= 1'b0;
      else if (adv) dv_r[k] <= pv;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[k] <= ge ? prem - shd : prem;
        ddiv_r[k] <= pdiv;
        dq_r[k]   <= pq | (17'(ge) << (ND - 1 - k));
        dfwd_r[k] <= pfwd;
        drev_r[k] <= prev;
        dds_r[k]  <= pds;
        dde_r[k]  <= pde;
        for (int i = 0; i < 3; i++) begin
          ddel_r[k][i]  <= pdel[i];
          dfrom_r[k][i] <= pfrom[i];
        end
      end
    end
  end

  // ---------------- H1: alpha times segment ----------------
  logic               v4_r, fwd4_r, rev4_r;
  logic [16:0]        al4_r;
  logic signed [27:0] ds4_r, de4_r;
  logic signed [39:0] pa4_r [3];
  logic signed [20:0] from4_r [3];
  logic signed [17:0] al_s;
  assign al_s = $signed({1'b0, dq_r[ND-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= dv_r[ND-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd4_r <= dfwd_r[ND-1];
      rev4_r <= drev_r[ND-1];
      al4_r  <= dq_r[ND-1];
      ds4_r  <= dds_r[ND-1];
      de4_r  <= dde_r[ND-1];
      for (int i = 0; i < 3; i++) begin
        pa4_r[i]   <= ddel_r[ND-1][i] * al_s;
        from4_r[i] <= dfrom_r[ND-1][i];
      end
    end
  end

  // ---------------- H2: crossing point ----------------
  logic signed [39:0] pa_rnd [3];
  logic signed [26:0] hit16  [3];
  logic signed [27:0] rel    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_rnd[i] = (pa4_r[i] + 40'sd2048) >>> 12;
      hit16[i]  = 27'($signed({from4_r[i], 4'd0})) + pa_rnd[i][26:0];
      rel[i]    = 28'(hit16[i]) - 28'($signed({org[i], 4'd0}));
    end
  end

  logic               v5_r, fwd5_r, rev5_r;
  logic [16:0]        al5_r;
  logic signed [27:0] ds5_r, de5_r;
  logic signed [26:0] h5_r   [3];
  logic signed [27:0] rel5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd5_r <= fwd4_r;
      rev5_r <= rev4_r;
      al5_r  <= al4_r;
      ds5_r  <= ds4_r;
      de5_r  <= de4_r;
      for (int i = 0; i < 3; i++) begin
        h5_r[i]   <= hit16[i];
        rel5_r[i] <= rel[i];
      end
    end
  end

  // ---------------- H3: axis products ----------------
  logic               v6_r, fwd6_r, rev6_r;
  logic [16:0]        al6_r;
  logic signed [27:0] ds6_r, de6_r;
  logic signed [26:0] h6_r  [3];
  logic signed [43:0] pr6_r [3];
  logic signed [43:0] pu6_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd6_r <= fwd5_r;
      rev6_r <= rev5_r;
      al6_r  <= al5_r;
      ds6_r  <= ds5_r;
      de6_r  <= de5_r;
      for (int i = 0; i < 3; i++) begin
        h6_r[i]  <= h5_r[i];
        pr6_r[i] <= rel5_r[i] * rgt[i];
        pu6_r[i] <= rel5_r[i] * upa[i];
      end
    end
  end

  // ---------------- H4: offsets ----------------
  logic signed [45:0] sum_r, sum_u, rnd_r, rnd_u;
  assign sum_r = 46'(pr6_r[0]) + 46'(pr6_r[1]) + 46'(pr6_r[2]);
  assign sum_u = 46'(pu6_r[0]) + 46'(pu6_r[1]) + 46'(pu6_r[2]);
  assign rnd_r = (sum_r + 46'sd8192) >>> 14;
  assign rnd_u = (sum_u + 46'sd8192) >>> 14;

  logic               v7_r, fwd7_r, rev7_r;
  logic [16:0]        al7_r;
  logic signed [27:0] ds7_r, de7_r, lat7_r, vrt7_r;
  logic signed [26:0] h7_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd7_r <= fwd6_r;
      rev7_r <= rev6_r;
      al7_r  <= al6_r;
      ds7_r  <= ds6_r;
      de7_r  <= de6_r;
      lat7_r <= sgct_pkg::sat28(48'(rnd_r));
      vrt7_r <= sgct_pkg::sat28(48'(rnd_u));
      for (int i = 0; i < 3; i++) h7_r[i] <= h6_r[i];
    end
  end

  // ---------------- H5: squares and extent ----------------
  logic [27:0] abs_lat, abs_vrt;
  assign abs_lat = lat7_r[27] ? 28'(-lat7_r) : 28'(lat7_r);
  assign abs_vrt = vrt7_r[27] ? 28'(-vrt7_r) : 28'(vrt7_r);

  logic               v8_r, fwd8_r, rev8_r, in8_r;
  logic [16:0]        al8_r;
  logic signed [27:0] ds8_r, de8_r, lat8_r, vrt8_r;
  logic signed [26:0] h8_r [3];
  logic [55:0]        lsq8_r, vsq8_r;
  logic [39:0]        wsq8_r, hsq8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (adv) v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd8_r <= fwd7_r;
      rev8_r <= rev7_r;
      al8_r  <= al7_r;
      ds8_r  <= ds7_r;
      de8_r  <= de7_r;
      lat8_r <= lat7_r;
      vrt8_r <= vrt7_r;
      lsq8_r <= abs_lat * abs_lat;
      vsq8_r <= abs_vrt * abs_vrt;
      wsq8_r <= hw_r * hw_r;
      hsq8_r <= hh_r * hh_r;
      in8_r  <= (abs_lat <= {4'd0, hw_r, 4'd0}) && (abs_vrt <= {4'd0, hh_r, 4'd0});
      for (int i = 0; i < 3; i++) h8_r[i] <= h7_r[i];
    end
  end

  // ---------------- H6: decision and output register ----------------
  logic [56:0] mag;
  logic [56:0] lim;
  logic        far, hit_ok, dir_ok;
  logic signed [26:0] hr [3];
  assign mag = 57'(lsq8_r) + 57'(vsq8_r);
  assign lim = {4'd0, 41'(wsq8_r) + 41'(hsq8_r), 12'd0};
  assign far = mag > lim;
  assign hit_ok = (fwd8_r || rev8_r) && !far;
  assign dir_ok = fwd8_r ? (legal_r == sgct_pkg::DIR_FWD || legal_r == sgct_pkg::DIR_BOTH)
                         : (legal_r == sgct_pkg::DIR_REV || legal_r == sgct_pkg::DIR_BOTH);

  always_comb begin
    for (int i = 0; i < 3; i++) hr[i] = (h8_r[i] + 27'sd8) >>> 4;
  end

  logic [1:0]         kind_r;
  logic               ok_r;
  logic [16:0]        alpha_r;
  logic signed [27:0] ds_r, de_r, lat_r, vrt_r;
  logic signed [20:0] hx_r, hy_r, hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r <= ds8_r;
      de_r <= de8_r;
      if (hit_ok) begin
        alpha_r <= al8_r;
        lat_r   <= lat8_r;
        vrt_r   <= vrt8_r;
        hx_r    <= hr[0][20:0];
        hy_r    <= hr[1][20:0];
        hz_r    <= hr[2][20:0];
        if (!in8_r) begin
          kind_r <= sgct_pkg::KIND_OUTSIDE;
          ok_r   <= 1'b0;
        end else begin
          kind_r <= fwd8_r ? sgct_pkg::KIND_FWD : sgct_pkg::KIND_REV;
          ok_r   <= dir_ok;
        end
      end else begin
        kind_r  <= sgct_pkg::KIND_NONE;
        ok_r    <= 1'b0;
        alpha_r <= '0;
        lat_r   <= '0;
        vrt_r   <= '0;
        hx_r    <= '0;
        hy_r    <= '0;
        hz_r    <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_crossing_kind   = kind_r;
  assign out_direction_ok    = ok_r;
  assign out_alpha           = alpha_r;
  assign out_dist_start      = ds_r;
  assign out_dist_end        = de_r;
  assign out_lateral_offset  = lat_r;
  assign out_vertical_offset = vrt_r;
  assign out_hit_x           = hx_r;
  assign out_hit_y           = hy_r;
  assign out_hit_z           = hz_r;

endmodule

FILE: tb/segment_gate_crossing_test_checker.sv
// Checker for the segment gate crossing test: predicts each request's result and compares.
module segment_gate_crossing_test_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [20:0]           in_from_x,
  input  logic signed [20:0]           in_from_y,
  input  logic signed [20:0]           in_from_z,
  input  logic signed [20:0]           in_to_x,
  input  logic signed [20:0]           in_to_y,
  input  logic signed [20:0]           in_to_z,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   out_crossing_kind,
  input  logic                         out_direction_ok,
  input  logic [16:0]                  out_alpha,
  input  logic signed [27:0]           out_dist_start,
  input  logic signed [27:0]           out_dist_end,
  input  logic signed [27:0]           out_lateral_offset,
  input  logic signed [27:0]           out_vertical_offset,
  input  logic signed [20:0]           out_hit_x,
  input  logic signed [20:0]           out_hit_y,
  input  logic signed [20:0]           out_hit_z,
  input  logic                         cfg_we,
  input  logic [sgct_pkg::CIDXW-1:0]   cfg_index,
  input  logic [sgct_pkg::CFGW-1:0]    cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  typedef struct {
    logic [1:0]         kind;
    logic               dir_ok;
    logic [16:0]        alpha;
    logic signed [27:0] dist_s;
    logic signed [27:0] dist_e;
    logic signed [27:0] lat;
    logic signed [27:0] vert;
    logic signed [20:0] hit_x;
    logic signed [20:0] hit_y;
    logic signed [20:0] hit_z;
  } crossing_t;

  logic [62:0]     origin_r;
  logic [47:0]     normal_r, right_r, up_r;
  logic [19:0]     half_w_r, half_h_r;
  logic [1:0]      legal_r;
  crossing_t       crossings_due[$];
  int              errors = 0;

  assign fail_count = errors;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp28(longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic crossing_t predict_crossing(longint f[3], longint t[3]);
    crossing_t res;
    longint o[3], n[3], r[3], u[3], h16[3], rel[3];
    longint ds, de, num, den, al, lat, vert, hw, hh;
    longint unsigned mag, lim;
    bit fwd, rev, ok;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'($signed(origin_r[21*i +: 21]));
      n[i] = longint'($signed(normal_r[16*i +: 16]));
      r[i] = longint'($signed(right_r[16*i +: 16]));
      u[i] = longint'($signed(up_r[16*i +: 16]));
    end
    res = '{default: '0};
    ds = clamp28(round_shift((f[0]-o[0])*n[0] + (f[1]-o[1])*n[1] + (f[2]-o[2])*n[2], 10));
    de = clamp28(round_shift((t[0]-o[0])*n[0] + (t[1]-o[1])*n[1] + (t[2]-o[2])*n[2], 10));
    res.dist_s = ds[27:0];
    res.dist_e = de[27:0];
    fwd = (ds < 0) && (de >= 0);
    rev = (de < 0) && (ds >= 0);
    if (!fwd && !rev) return res;
    num = fwd ? -ds : ds;
    den = fwd ? (de - ds) : (ds - de);
    al = ((num << 17) + den) / (2 * den);
    for (int i = 0; i < 3; i++) begin
      h16[i] = f[i] * 16 + round_shift((t[i] - f[i]) * al, 12);
      rel[i] = h16[i] - o[i] * 16;
    end
    lat  = clamp28(round_shift(rel[0]*r[0] + rel[1]*r[1] + rel[2]*r[2], 14));
    vert = clamp28(round_shift(rel[0]*u[0] + rel[1]*u[1] + rel[2]*u[2], 14));
    hw = longint'(half_w_r);
    hh = longint'(half_h_r);
    mag = longint'(lat * lat) + longint'(vert * vert);
    lim = (hw * hw + hh * hh) << 12;
    // far hit beyond four half-diagonals reads as no crossing
    if (mag > lim) return res;
    res.alpha = al[16:0];
    res.lat = lat[27:0];
    res.vert = vert[27:0];
    res.hit_x = 21'(round_shift(h16[0], 4));
    res.hit_y = 21'(round_shift(h16[1], 4));
    res.hit_z = 21'(round_shift(h16[2], 4));
    if (absl(lat) > hw * 16 || absl(vert) > hh * 16) begin
      res.kind = sgct_pkg::KIND_OUTSIDE;
      return res;
    end
    if (fwd) ok = (legal_r == sgct_pkg::DIR_FWD) || (legal_r == sgct_pkg::DIR_BOTH);
    else ok = (legal_r == sgct_pkg::DIR_REV) || (legal_r == sgct_pkg::DIR_BOTH);
    res.kind = fwd ? sgct_pkg::KIND_FWD : sgct_pkg::KIND_REV;
    res.dir_ok = ok;
    return res;
  endfunction

  task automatic check_field(string nm, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", nm, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    crossing_t e;
    longint f[3], t[3];
    if (!rst_n) begin
      origin_r <= '0;
      normal_r <= '0;
      right_r <= '0;
      up_r <= '0;
      half_w_r <= 20'd1;
      half_h_r <= 20'd1;
      legal_r <= sgct_pkg::DIR_FWD;
      crossings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgct_pkg::REG_ORIGIN: origin_r <= cfg_wdata[62:0];
          sgct_pkg::REG_NORMAL: normal_r <= cfg_wdata[47:0];
          sgct_pkg::REG_RIGHT:  right_r <= cfg_wdata[47:0];
          sgct_pkg::REG_UP:     up_r <= cfg_wdata[47:0];
          sgct_pkg::REG_HALF_W: half_w_r <= cfg_wdata[19:0];
          sgct_pkg::REG_HALF_H: half_h_r <= cfg_wdata[19:0];
          sgct_pkg::REG_LEGAL:  legal_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        f = '{longint'(in_from_x), longint'(in_from_y), longint'(in_from_z)};
        t = '{longint'(in_to_x), longint'(in_to_y), longint'(in_to_z)};
        crossings_due.push_back(predict_crossing(f, t));
      end
      if (out_valid && !out_stall) begin
        if (crossings_due.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = crossings_due.pop_front();
          check_field("crossing_kind", longint'(e.kind), longint'(out_crossing_kind));
          check_field("direction_ok", longint'(e.dir_ok), longint'(out_direction_ok));
          check_field("alpha", longint'(e.alpha), longint'(out_alpha));
          check_field("dist_start", longint'(e.dist_s), longint'(out_dist_start));
          check_field("dist_end", longint'(e.dist_e), longint'(out_dist_end));
          check_field("lateral_offset", longint'(e.lat), longint'(out_lateral_offset));
          check_field("vertical_offset", longint'(e.vert), longint'(out_vertical_offset));
          check_field("hit_x", longint'(e.hit_x), longint'(out_hit_x));
          check_field("hit_y", longint'(e.hit_y), longint'(out_hit_y));
          check_field("hit_z", longint'(e.hit_z), longint'(out_hit_z));
        end
      end
    end
    pending = crossings_due.size();
  end

endmodule

FILE: tb/segment_gate_crossing_test_tb.sv
// Top of the segment gate crossing test bench: stimulus, gate setups and verdict.
module segment_gate_crossing_test_tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [20:0]  in_from_x = '0, in_from_y = '0, in_from_z = '0;
  logic signed [20:0]  in_to_x = '0, in_to_y = '0, in_to_z = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_crossing_kind;
  logic                out_direction_ok;
  logic [16:0]         out_alpha;
  logic signed [27:0]  out_dist_start, out_dist_end, out_lateral_offset, out_vertical_offset;
  logic signed [20:0]  out_hit_x, out_hit_y, out_hit_z;
  logic                cfg_we = 1'b0;
  logic [sgct_pkg::CIDXW-1:0] cfg_index = '0;
  logic [sgct_pkg::CFGW-1:0]  cfg_wdata = '0;
  int                  fail_count, pending;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_go = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  org[3];

  always #10 clk = ~clk;

  segment_gate_crossing_test dut (.*);
  segment_gate_crossing_test_checker chk (.*);

  // receiver: random stalls, plus one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send(int fx, int fy, int fz, int tx, int ty, int tz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_from_x <= fx[20:0];
    in_from_y <= fy[20:0];
    in_from_z <= fz[20:0];
    in_to_x <= tx[20:0];
    in_to_y <= ty[20:0];
    in_to_z <= tz[20:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(sgct_pkg::cfg_reg_t idx, logic [sgct_pkg::CFGW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] pack_axis(int a[3]);
    return {a[2][15:0], a[1][15:0], a[0][15:0]};
  endfunction

  // axis-aligned frame with random signs, or raw random axes now and then
  task automatic set_gate(int ox, int oy, int oz, int hw, int hh, sgct_pkg::dir_t legal,
                          bit raw_axes);
    int n[3], r[3], u[3];
    int p0, p1, p2;
    n = '{0, 0, 0};
    r = '{0, 0, 0};
    u = '{0, 0, 0};
    p0 = $urandom_range(2);
    p1 = (p0 + 1 + $urandom_range(1)) % 3;
    p2 = 3 - p0 - p1;
    n[p0] = $urandom_range(1) ? 16384 : -16384;
    r[p1] = $urandom_range(1) ? 16384 : -16384;
    u[p2] = $urandom_range(1) ? 16384 : -16384;
    org = '{ox, oy, oz};
    write_reg(sgct_pkg::REG_ORIGIN, {oz[20:0], oy[20:0], ox[20:0]});
    if (raw_axes) begin
      write_reg(sgct_pkg::REG_NORMAL, sgct_pkg::CFGW'({$urandom, $urandom}));
      write_reg(sgct_pkg::REG_RIGHT, sgct_pkg::CFGW'({$urandom, $urandom}));
      write_reg(sgct_pkg::REG_UP, sgct_pkg::CFGW'({$urandom, $urandom}));
    end else begin
      write_reg(sgct_pkg::REG_NORMAL, sgct_pkg::CFGW'(pack_axis(n)));
      write_reg(sgct_pkg::REG_RIGHT, sgct_pkg::CFGW'(pack_axis(r)));
      write_reg(sgct_pkg::REG_UP, sgct_pkg::CFGW'(pack_axis(u)));
    end
    write_reg(sgct_pkg::REG_HALF_W, sgct_pkg::CFGW'(hw));
    write_reg(sgct_pkg::REG_HALF_H, sgct_pkg::CFGW'(hh));
    write_reg(sgct_pkg::REG_LEGAL, sgct_pkg::CFGW'(legal));
    @(posedge clk);
  endtask

  function automatic int near(int i, int span);
    return org[i] + $signed($urandom_range(2 * span)) - span;
  endfunction

  initial begin
    int span, done;
    int m, x;
    m = 1048576;
    x = 1048575;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gate: zero normal, nothing crosses
    send(-m, x, 0, x, -m, 5);
    send(1, 2, 3, -4, -5, -6);
    drain();

    // directed: normal along x, gate 200 x 100 cm at the origin
    write_reg(sgct_pkg::REG_NORMAL, sgct_pkg::CFGW'(pack_axis('{16384, 0, 0})));
    write_reg(sgct_pkg::REG_RIGHT, sgct_pkg::CFGW'(pack_axis('{0, 16384, 0})));
    write_reg(sgct_pkg::REG_UP, sgct_pkg::CFGW'(pack_axis('{0, 0, 16384})));
    write_reg(sgct_pkg::REG_HALF_W, sgct_pkg::CFGW'(100));
    write_reg(sgct_pkg::REG_HALF_H, sgct_pkg::CFGW'(50));
    write_reg(sgct_pkg::REG_LEGAL, sgct_pkg::CFGW'(sgct_pkg::DIR_FWD));
    @(posedge clk);
    org = '{0, 0, 0};
    send(-100, 10, 5, 100, 10, 5);      // forward inside
    send(100, -20, 7, -300, -20, 7);    // reverse inside, not legal
    send(-10, 0, 0, 0, 0, 0);           // ends on plane: forward
    send(0, 0, 0, 10, 0, 0);            // starts on plane: no crossing
    send(0, 0, 0, -10, 0, 0);           // starts on plane, goes back: reverse
    send(-50, 150, 0, 50, 150, 0);      // outside extent
    send(-50, 0, 80, 50, 0, 80);        // outside vertically
    send(-50, 1000, 0, 50, 1000, 0);    // far hit
    send(-1, 0, 0, x, 0, 0);            // tiny alpha
    send(-m, 3, 3, 1, 3, 3);            // alpha near one
    send(-m, -m, -m, x, x, x);          // extremes, crossing inside
    send(x, x, x, -m, -m, -m);
    send(5, 5, 5, 6, 6, 6);             // same side
    send(-7, 4, 4, -7, 4, 4);           // zero length
    drain();
    write_reg(sgct_pkg::REG_LEGAL, sgct_pkg::CFGW'(sgct_pkg::DIR_BOTH));
    send(100, -20, 7, -300, -20, 7);
    drain();
    write_reg(sgct_pkg::REG_LEGAL, sgct_pkg::CFGW'(sgct_pkg::DIR_NONE));
    send(-100, 10, 5, 100, 10, 5);
    send(100, -20, 7, -300, -20, 7);
    drain();
    write_reg(sgct_pkg::REG_HALF_W, sgct_pkg::CFGW'(0));           // zero half size
    send(-100, 0, 0, 100, 0, 0);
    send(-100, 1, 0, 100, 1, 0);
    drain();

    done = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gate(0, 0, 0, 100, 50, sgct_pkg::DIR_FWD, 1'b0);
        1: set_gate(x, -m, 12345, 1048575, 1048575, sgct_pkg::DIR_REV, 1'b0);
        2: set_gate(-500, 300, 70, 1, 1, sgct_pkg::DIR_BOTH, 1'b0);
        3: set_gate(200, -200, 0, 0, 40, sgct_pkg::DIR_NONE, 1'b0);
        4: set_gate(-m, x, -m, 3000, 200, sgct_pkg::DIR_BOTH, 1'b1);
        5: set_gate($signed($urandom_range(4000)) - 2000, 0, 9, 700, 1200,
                    sgct_pkg::DIR_FWD, 1'b0);
        6: set_gate(1000, 1000, -1000, 50, 60, sgct_pkg::DIR_REV, 1'b1);
        default: set_gate(0, 0, 0, 2000, 2000, sgct_pkg::DIR_BOTH, 1'b0);
      endcase
      if (ph == 1) hold_go <= 1'b1;
      for (int k = 0; k < 205; k++) begin
        if (done < 550) begin
          send_idle_pct = 35;
          recv_idle_pct = 63;
        end else if (done < 1100) begin
          send_idle_pct = 63;
          recv_idle_pct = 35;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        span = ($urandom_range(3) == 0) ? 20000 : 300;
        if ($urandom_range(9) < 2)
          send($signed($urandom), $signed($urandom), $signed($urandom),
               $signed($urandom), $signed($urandom), $signed($urandom));
        else
          send(near(0, span), near(1, span), near(2, span),
               near(0, span), near(1, span), near(2, span));
        done++;
      end
      drain();
    end

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end

endmodule
